// ===== hw/rtl/opa_pkg.sv =====
// opa_pkg: types, codes and sizes shared by the object pool allocator
// used by opa_ram users and by object_pool_allocator; depends on nothing

package opa_pkg;

   localparam int POOL_SIZE = 256;
   localparam int HANDLE_W  = 8;
   localparam int ADDR_W    = $clog2(POOL_SIZE);
   localparam int COUNT_W   = ADDR_W + 1;

   // request codes
   localparam logic [1:0] REQ_ALLOC   = 2'd0;
   localparam logic [1:0] REQ_TRY     = 2'd1;
   localparam logic [1:0] REQ_RELEASE = 2'd2;

   // status codes
   localparam logic [1:0] STAT_OK          = 2'd0;
   localparam logic [1:0] STAT_EMPTY       = 2'd1;
   localparam logic [1:0] STAT_BAD_RELEASE = 2'd2;
   localparam logic [1:0] STAT_EXHAUSTED   = 2'd3;

   typedef struct packed {
      logic [1:0]          req_type;
      logic [HANDLE_W-1:0] handle;
   } req_beat_type;

   typedef struct packed {
      logic [HANDLE_W-1:0] granted_handle;
      logic [1:0]          status;
   } rsp_beat_type;

   typedef enum logic [1:0] {
      S_CLEAR,
      S_IDLE,
      S_LOOKUP
   } state_type;

endpackage

// ===== hw/rtl/object_pool_allocator.sv =====
// object_pool_allocator: handle pool with fifo free queue and in-use bitmap
// depends on opa_pkg and two opa_ram instances (free queue, in-use map)
//
//   channel | direction | beat          | handshake
//   req     | in        | req_beat_type | req_valid / req_stall
//   rsp     | out       | rsp_beat_type | rsp_valid / rsp_stall
//
// a new request is taken only in idle: accept issues the ram reads, the next cycle
// uses the registered read data, writes back and loads the result register
// after reset the in-use map is cleared one entry a cycle, all 256 entries, with
// req_stall high
// a stalled result holds the lookup cycle until the result register frees

module object_pool_allocator (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  opa_pkg::req_beat_type req_beat,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output opa_pkg::rsp_beat_type rsp_beat
);

   import opa_pkg::*;

   state_type           state_ff, state_in;
   logic [ADDR_W-1:0]   clear_idx_ff, clear_idx_in;
   logic [ADDR_W-1:0]   head_ff, head_in;
   logic [ADDR_W-1:0]   tail_ff, tail_in;
   logic [COUNT_W-1:0]  count_ff, count_in;
   logic [COUNT_W-1:0]  fresh_ff, fresh_in;
   req_beat_type        req_ff, req_in;
   logic                rsp_valid_ff, rsp_valid_in;
   rsp_beat_type        rsp_beat_ff, rsp_beat_in;

   logic                accept;
   logic                finish;

   logic                q_wr_en;
   logic [ADDR_W-1:0]   q_wr_addr;
   logic [HANDLE_W-1:0] q_wr_data;
   logic [HANDLE_W-1:0] q_rd_data;

   logic                use_wr_en;
   logic [ADDR_W-1:0]   use_wr_addr;
   logic [0:0]          use_wr_data;
   logic [0:0]          use_rd_data;

   logic                do_pop, do_push, do_fresh;
   rsp_beat_type        result;

   opa_ram #(.WIDTH(HANDLE_W), .DEPTH(POOL_SIZE)) u_free_queue (
      .clock   (clock),
      .wr_en   (q_wr_en),
      .wr_addr (q_wr_addr),
      .wr_data (q_wr_data),
      .rd_en   (accept),
      .rd_addr (head_ff),
      .rd_data (q_rd_data)
   );

   opa_ram #(.WIDTH(1), .DEPTH(POOL_SIZE)) u_in_use (
      .clock   (clock),
      .wr_en   (use_wr_en),
      .wr_addr (use_wr_addr),
      .wr_data (use_wr_data),
      .rd_en   (accept),
      .rd_addr (req_beat.handle[ADDR_W-1:0]),
      .rd_data (use_rd_data)
   );

   assign req_stall = (state_ff != S_IDLE);
   assign accept    = req_valid && !req_stall;
   assign finish    = (state_ff == S_LOOKUP) && (!rsp_valid_ff || !rsp_stall);

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_CLEAR: begin
            if (clear_idx_ff == ADDR_W'(POOL_SIZE - 1)) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (accept) begin
               state_in = S_LOOKUP;
            end
         end
         S_LOOKUP: begin
            if (finish) begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_CLEAR;
      endcase
   end

   // per-request decision and memory writes
   always_comb begin
      result      = '0;
      do_pop      = 1'b0;
      do_push     = 1'b0;
      do_fresh    = 1'b0;
      use_wr_en   = 1'b0;
      use_wr_addr = clear_idx_ff;
      use_wr_data = 1'b0;
      q_wr_en     = 1'b0;
      q_wr_addr   = tail_ff;
      q_wr_data   = req_ff.handle;
      case (state_ff)
         S_CLEAR: begin
            use_wr_en = 1'b1;
         end
         S_LOOKUP: begin
            case (req_ff.req_type)
               REQ_ALLOC, REQ_TRY: begin
                  if (count_ff != '0) begin
                     do_pop                = finish;
                     result.granted_handle = q_rd_data;
                     use_wr_en             = finish;
                     use_wr_addr           = q_rd_data[ADDR_W-1:0];
                     use_wr_data           = 1'b1;
                  end else if (req_ff.req_type == REQ_TRY) begin
                     result.status = STAT_EMPTY;
                  end else if (fresh_ff[COUNT_W-1]) begin
                     result.status = STAT_EXHAUSTED;
                  end else begin
                     do_fresh              = finish;
                     result.granted_handle = HANDLE_W'(fresh_ff[ADDR_W-1:0]);
                     use_wr_en             = finish;
                     use_wr_addr           = fresh_ff[ADDR_W-1:0];
                     use_wr_data           = 1'b1;
                  end
               end
               REQ_RELEASE: begin
                  if (use_rd_data[0]) begin
                     do_push     = finish;
                     use_wr_en   = finish;
                     use_wr_addr = req_ff.handle[ADDR_W-1:0];
                     use_wr_data = 1'b0;
                     q_wr_en     = finish;
                  end else begin
                     result.status = STAT_BAD_RELEASE;
                  end
               end
               default: result = '0;
            endcase
         end
         default: result = '0;
      endcase
   end

   always_comb begin
      clear_idx_in = clear_idx_ff;
      if (state_ff == S_CLEAR) begin
         clear_idx_in = clear_idx_ff + ADDR_W'(1);
      end
      req_in       = accept ? req_beat : req_ff;
      head_in      = do_pop ? head_ff + ADDR_W'(1) : head_ff;
      tail_in      = do_push ? tail_ff + ADDR_W'(1) : tail_ff;
      fresh_in     = do_fresh ? fresh_ff + COUNT_W'(1) : fresh_ff;
      count_in     = count_ff;
      if (do_pop) begin
         count_in = count_ff - COUNT_W'(1);
      end else if (do_push) begin
         count_in = count_ff + COUNT_W'(1);
      end
      rsp_valid_in = finish || (rsp_valid_ff && rsp_stall);
      rsp_beat_in  = finish ? result : rsp_beat_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         clear_idx_ff <= '0;
         head_ff      <= '0;
         tail_ff      <= '0;
         count_ff     <= '0;
         fresh_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clear_idx_ff <= clear_idx_in;
         head_ff      <= head_in;
         tail_ff      <= tail_in;
         count_ff     <= count_in;
         fresh_ff     <= fresh_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      req_ff      <= req_in;
      rsp_beat_ff <= rsp_beat_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_beat  = rsp_beat_ff;

endmodule

// ===== hw/rtl/opa_ram.sv =====
// opa_ram: generic single-write, single-read synchronous ram
// read data registered; no dependencies

module opa_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule
